@@ rtl/hid_keyboard_report_to_scancodes_top_macros.svh @@
// assertion helpers used by the checker file
`ifndef HID_KEYBOARD_REPORT_TO_SCANCODES_TOP_MACROS_SVH
`define HID_KEYBOARD_REPORT_TO_SCANCODES_TOP_MACROS_SVH

// implication checked every clock edge, off while reset is asserted
`define HKBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked every clock edge, reset included
`define HKBS_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/hkbs_pkg.sv @@
package hkbs_pkg;

    // default number of stored key slots
    localparam int KeySlotsDefault = 6;
    // key slots carried by one report
    localparam int InputSlots      = 6;
    localparam int MapSize         = 14;
    localparam logic [6:0] MinReportLen     = 7'd8;
    localparam logic [7:0] GamepadId        = 8'h01;
    localparam logic [7:0] GamepadAxisLimit = 8'h40;

    // operation codes
    localparam logic OpReport  = 1'b0;
    localparam logic OpRemoved = 1'b1;

    // usage to scancode map
    localparam logic [7:0] UsageRom [MapSize] = '{
        8'h1A, 8'h04, 8'h16, 8'h07, 8'h1D, 8'h52, 8'h51,
        8'h50, 8'h4F, 8'h2C, 8'h2B, 8'h28, 8'h29, 8'hE0
    };
    localparam logic [7:0] ScancodeRom [MapSize] = '{
        8'h11, 8'h1e, 8'h1f, 8'h20, 8'h2c, 8'h5a, 8'h6a,
        8'h6b, 8'h6c, 8'h39, 8'h0f, 8'h1c, 8'h01, 8'h1d
    };

    typedef struct packed {
        logic       operation;
        logic [6:0] report_length;
        logic [7:0] modifier_byte;
        logic [7:0] reserved_byte;
        logic [7:0] slot_zero;
        logic [7:0] slot_one;
        logic [7:0] slot_two;
        logic [7:0] slot_three;
        logic [7:0] slot_four;
        logic [7:0] slot_five;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] scancode;
        logic       pressed;
        logic       last;
    } t_out_beat;

    // what one lane found for its slot
    typedef struct packed {
        logic       rel_valid;
        logic [7:0] rel_sc;
        logic       prs_valid;
        logic [7:0] prs_sc;
    } t_lane_evt;

    // map a usage, zero when it has no entry
    function automatic logic [7:0] lookup_scancode(input logic [7:0] usage);
        logic [7:0] sc;
        sc = 8'h00;
        for (int i = 0; i < MapSize; i++) begin
            if (UsageRom[i] == usage) begin
                sc = sc | ScancodeRom[i];
            end
        end
        return sc;
    endfunction

    // key slot k of a report, empty beyond the carried slots
    function automatic logic [7:0] report_slot(input t_in_beat b, input int k);
        logic [7:0] key;
        case (k)
            0:       key = b.slot_zero;
            1:       key = b.slot_one;
            2:       key = b.slot_two;
            3:       key = b.slot_three;
            4:       key = b.slot_four;
            5:       key = b.slot_five;
            default: key = 8'h00;
        endcase
        return key;
    endfunction

endpackage

@@ rtl/hid_keyboard_report_to_scancodes_top.sv @@
// Boot keyboard report to scancode translator. Each input beat carries one
// report or a device-removed notice; each output beat is one key event, with
// last set on the final event of a report. Key slots are compared against the
// stored previous report by one lane per slot, combinationally, and the
// lanes' releases and presses are queued into a pending buffer that feeds the
// output register one event per cycle while the output is not stalled. A report
// causes up to 2 * KEY_SLOTS events; the next
// report is taken in the cycle its predecessor's last event leaves the
// buffer, so reports with at most one event stream at one per cycle while the output is not stalled.
module hid_keyboard_report_to_scancodes_top
    import hkbs_pkg::*;
#(
    parameter int KEY_SLOTS = KeySlotsDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    logic [KEY_SLOTS-1:0][7:0] r_prev;
    logic [KEY_SLOTS-1:0][7:0] n_prev;
    logic [KEY_SLOTS-1:0][7:0] cur_keys;
    t_lane_evt [KEY_SLOTS-1:0] evt;
    logic                      accept;
    logic                      gamepad;
    logic                      report_ok;

    // current report slots
    always_comb begin
        for (int k = 0; k < KEY_SLOTS; k++) begin
            cur_keys[k] = report_slot(i_in_data, k);
        end
    end

    // report filter
    assign gamepad   = (i_in_data.modifier_byte == GamepadId) &&
                       !((i_in_data.slot_zero == 8'h00) &&
                         (i_in_data.reserved_byte < GamepadAxisLimit));
    assign report_ok = (i_in_data.operation == OpReport) &&
                       (i_in_data.report_length >= MinReportLen) && !gamepad;
    assign accept    = i_in_valid && o_in_ready;

    // one lane per key slot
    for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
        hkbs_lane #(
            .KEY_SLOTS(KEY_SLOTS)
        ) u_lane (
            .i_cur_key  (cur_keys[g]),
            .i_prev_key (r_prev[g]),
            .i_cur_keys (cur_keys),
            .i_prev_keys(r_prev),
            .o_evt      (evt[g])
        );
    end

    // stored keys
    always_comb begin
        n_prev = r_prev;
        if (accept) begin
            if (i_in_data.operation == OpRemoved) begin
                n_prev = '0;
            end else if (report_ok) begin
                n_prev = cur_keys;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else begin
            r_prev <= n_prev;
        end
    end

    // event queue and output register
    hkbs_merge #(
        .KEY_SLOTS(KEY_SLOTS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (accept && report_ok),
        .i_evt      (evt),
        .o_ready    (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

endmodule

@@ rtl/hkbs_lane.sv @@
module hkbs_lane
    import hkbs_pkg::*;
#(
    parameter int KEY_SLOTS = KeySlotsDefault
) (
    input  logic [7:0]                 i_cur_key,
    input  logic [7:0]                 i_prev_key,
    input  logic [KEY_SLOTS-1:0][7:0]  i_cur_keys,
    input  logic [KEY_SLOTS-1:0][7:0]  i_prev_keys,
    output t_lane_evt                  o_evt
);

    logic       prev_in_cur;
    logic       cur_in_prev;
    logic [7:0] rel_sc;
    logic [7:0] prs_sc;

    // membership of this slot's keys in the other report
    always_comb begin
        prev_in_cur = 1'b0;
        cur_in_prev = 1'b0;
        for (int k = 0; k < KEY_SLOTS; k++) begin
            if (i_cur_keys[k] == i_prev_key) begin
                prev_in_cur = 1'b1;
            end
            if (i_prev_keys[k] == i_cur_key) begin
                cur_in_prev = 1'b1;
            end
        end
    end

    // map and qualify release and press
    always_comb begin
        rel_sc          = lookup_scancode(i_prev_key);
        prs_sc          = lookup_scancode(i_cur_key);
        o_evt.rel_sc    = rel_sc;
        o_evt.prs_sc    = prs_sc;
        o_evt.rel_valid = (i_prev_key != 8'h00) && !prev_in_cur && (rel_sc != 8'h00);
        o_evt.prs_valid = (i_cur_key != 8'h00) && !cur_in_prev && (prs_sc != 8'h00);
    end

endmodule

@@ rtl/hkbs_merge.sv @@
module hkbs_merge
    import hkbs_pkg::*;
#(
    parameter int KEY_SLOTS = KeySlotsDefault
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  t_lane_evt [KEY_SLOTS-1:0]   i_evt,
    output logic                        o_ready,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output t_out_beat                   o_out_data
);

    localparam int EvCount = 2 * KEY_SLOTS;

    logic [EvCount-1:0]      r_pend;
    logic [EvCount-1:0]      n_pend;
    logic [EvCount-1:0][7:0] r_sc;
    logic [EvCount-1:0]      new_mask;
    logic [EvCount-1:0][7:0] new_sc;
    logic [EvCount-1:0]      pick;
    logic [EvCount-1:0]      rest;
    logic [7:0]              sel_sc;
    logic                    move;
    logic                    r_out_valid;
    t_out_beat               r_out_data;

    // releases in slot order first, then presses
    always_comb begin
        for (int k = 0; k < KEY_SLOTS; k++) begin
            new_mask[k]             = i_evt[k].rel_valid;
            new_sc[k]               = i_evt[k].rel_sc;
            new_mask[KEY_SLOTS + k] = i_evt[k].prs_valid;
            new_sc[KEY_SLOTS + k]   = i_evt[k].prs_sc;
        end
    end

    // lowest pending event goes next
    always_comb begin
        pick   = r_pend & (~r_pend + {{(EvCount-1){1'b0}}, 1'b1});
        rest   = r_pend & ~pick;
        sel_sc = 8'h00;
        for (int j = 0; j < EvCount; j++) begin
            if (pick[j]) begin
                sel_sc = sel_sc | r_sc[j];
            end
        end
    end

    assign move    = (r_pend != '0) && (!r_out_valid || i_out_ready);
    assign o_ready = (r_pend == '0) || (move && (rest == '0));

    always_comb begin
        n_pend = move ? rest : r_pend;
        if (i_take) begin
            n_pend = new_mask;
        end
    end

    // pending events
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
        if (i_take) begin
            r_sc <= new_sc;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (move) begin
            r_out_data.scancode <= sel_sc;
            r_out_data.pressed  <= (pick[EvCount-1:KEY_SLOTS] != '0);
            r_out_data.last     <= (rest == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ rtl/hkbs_checker.sv @@
`include "hid_keyboard_report_to_scancodes_top_macros.svh"

module hkbs_checker
    import hkbs_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_beat  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out_data
);

    // a stalled beat holds
    `HKBS_ASSERT_IMP(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready,
        ##1 (o_out_valid && $stable(o_out_data)))
    // a waiting input beat holds
    `HKBS_ASSERT_IMP(a_in_hold, i_clk, i_rst_n,
        i_in_valid && !o_in_ready,
        ##1 (i_in_valid && $stable(i_in_data)))
    // nothing shown right after reset
    `HKBS_ASSERT_NEXT(a_reset_idle, i_clk, !i_rst_n, !o_out_valid)
    // unmapped keys never leave the block
    `HKBS_ASSERT_IMP(a_sc_nonzero, i_clk, i_rst_n, o_out_valid, o_out_data.scancode != 8'h00)
    // no report is taken while a stalled event that is not a report's last is shown
    `HKBS_ASSERT_IMP(a_no_take_mid, i_clk, i_rst_n,
        o_out_valid && !o_out_data.last && !i_out_ready,
        !o_in_ready)

endmodule

bind hid_keyboard_report_to_scancodes_top hkbs_checker u_hkbs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

@@ tb/sv/tb_hid_keyboard_report_to_scancodes_top.sv @@
module tb_hid_keyboard_report_to_scancodes_top;
    import hkbs_pkg::*;

    localparam int KeySlots      = KeySlotsDefault;
    localparam int MostEvents    = 2 * KeySlots;
    localparam int RandomReports = 300;
    localparam int CycleLimit    = 400000;
    localparam int LongHold      = 300;

    typedef logic [7:0] t_key_row [KeySlots];

    // usages that have a scancode, used to bias the stimulus
    localparam logic [7:0] KnownUsages [14] = '{
        8'h1A, 8'h04, 8'h16, 8'h07, 8'h1D, 8'h52, 8'h51,
        8'h50, 8'h4F, 8'h2C, 8'h2B, 8'h28, 8'h29, 8'hE0
    };

    // tracks held keys and the key events each report should produce
    class key_event_ledger;
        t_key_row  held_keys;
        t_out_beat due_events[$];
        int        fault_count;

        function new();
            foreach (held_keys[i]) held_keys[i] = 8'h00;
            fault_count = 0;
        endfunction

        function logic [7:0] game_code(logic [7:0] usage);
            case (usage)
                8'h1A:   return 8'h11;
                8'h04:   return 8'h1e;
                8'h16:   return 8'h1f;
                8'h07:   return 8'h20;
                8'h1D:   return 8'h2c;
                8'h52:   return 8'h5a;
                8'h51:   return 8'h6a;
                8'h50:   return 8'h6b;
                8'h4F:   return 8'h6c;
                8'h2C:   return 8'h39;
                8'h2B:   return 8'h0f;
                8'h28:   return 8'h1c;
                8'h29:   return 8'h01;
                8'hE0:   return 8'h1d;
                default: return 8'h00;
            endcase
        endfunction

        function bit row_has(t_key_row row, logic [7:0] usage);
            if (usage == 8'h00) return 1'b0;
            foreach (row[i]) begin
                if (row[i] == usage) return 1'b1;
            end
            return 1'b0;
        endfunction

        function int pending();
            return due_events.size();
        endfunction

        // note an accepted report beat; returns 1 when the block acts on it
        function bit take_report(t_in_beat b);
            t_key_row   now_keys;
            logic [7:0] carried [InputSlots];
            logic [7:0] code;
            t_out_beat  burst[$];
            t_out_beat  tail;
            carried = '{b.slot_zero, b.slot_one, b.slot_two,
                        b.slot_three, b.slot_four, b.slot_five};
            if (b.operation == OpRemoved) begin
                foreach (held_keys[i]) held_keys[i] = 8'h00;
                return 1'b1;
            end
            if (b.report_length < MinReportLen) return 1'b0;
            if (b.modifier_byte == GamepadId &&
                !(b.slot_zero == 8'h00 && b.reserved_byte < GamepadAxisLimit)) begin
                return 1'b0;
            end
            foreach (now_keys[i]) now_keys[i] = (i < InputSlots) ? carried[i] : 8'h00;
            // releases of held keys that are gone, in slot order
            foreach (held_keys[i]) begin
                code = game_code(held_keys[i]);
                if (held_keys[i] != 8'h00 && !row_has(now_keys, held_keys[i]) && code != 0) begin
                    burst.push_back('{code, 1'b0, 1'b0});
                end
            end
            // presses of new keys, in slot order
            foreach (now_keys[i]) begin
                code = game_code(now_keys[i]);
                if (now_keys[i] != 8'h00 && !row_has(held_keys, now_keys[i]) && code != 0) begin
                    burst.push_back('{code, 1'b1, 1'b0});
                end
            end
            held_keys = now_keys;
            if (burst.size() > 0) begin
                tail = burst.pop_back();
                tail.last = 1'b1;
                burst.push_back(tail);
            end
            foreach (burst[i]) due_events.push_back(burst[i]);
            return 1'b1;
        endfunction

        // compare one output beat against the oldest due event
        function void match_event(t_out_beat got);
            t_out_beat want;
            if (due_events.size() == 0) begin
                $error("unexpected event: scancode %h pressed %b last %b",
                       got.scancode, got.pressed, got.last);
                fault_count++;
                return;
            end
            want = due_events.pop_front();
            if (got.scancode !== want.scancode) begin
                $error("scancode: expected %h, got %h", want.scancode, got.scancode);
                fault_count++;
            end
            if (got.pressed !== want.pressed) begin
                $error("pressed: expected %b, got %b", want.pressed, got.pressed);
                fault_count++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %b, got %b", want.last, got.last);
                fault_count++;
            end
        endfunction

        function void close_out();
            if (due_events.size() != 0) begin
                $error("%0d events never arrived", due_events.size());
                fault_count++;
            end
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_beat  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_beat o_out_data;

    key_event_ledger ledger = new();

    bit steady     = 1'b0;
    bit hold_req   = 1'b0;
    int hold_left  = 0;
    int cycle_count = 0;

    hid_keyboard_report_to_scancodes_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // watchdog
    initial begin
        while (cycle_count < CycleLimit) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    // event sink: check accepted beats, then pick next ready
    initial begin
        bit ready_next;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) ledger.match_event(o_out_data);
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LongHold;
                ready_next = 1'b0;
            end else begin
                ready_next = steady || ($urandom_range(99) >= 26);
            end
            i_out_ready <= ready_next;
        end
    end

    function automatic t_in_beat keyboard_report(input logic [6:0] len, input logic [7:0] mdf,
            input logic [7:0] rsv, input logic [7:0] k0, input logic [7:0] k1,
            input logic [7:0] k2, input logic [7:0] k3, input logic [7:0] k4,
            input logic [7:0] k5);
        t_in_beat b;
        b.operation     = OpReport;
        b.report_length = len;
        b.modifier_byte = mdf;
        b.reserved_byte = rsv;
        b.slot_zero     = k0;
        b.slot_one      = k1;
        b.slot_two      = k2;
        b.slot_three    = k3;
        b.slot_four     = k4;
        b.slot_five     = k5;
        return b;
    endfunction

    function automatic t_in_beat removal_notice();
        t_in_beat b;
        b = keyboard_report(7'($urandom_range(127)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255)));
        b.operation = OpRemoved;
        return b;
    endfunction

    // often keep the key, else a mapped, unmapped or empty one
    function automatic logic [7:0] pick_key(input logic [7:0] prior);
        int r;
        r = $urandom_range(99);
        if (r < 40) return prior;
        if (r < 75) return KnownUsages[4'($urandom_range(13))];
        if (r < 85) return 8'($urandom_range(255));
        return 8'h00;
    endfunction

    function automatic t_in_beat random_report(input t_in_beat prior);
        t_in_beat b;
        int       r;
        b = keyboard_report(7'($urandom_range(8, 64)), 8'($urandom_range(255)),
                            8'($urandom_range(255)),
                            pick_key(prior.slot_zero), pick_key(prior.slot_one),
                            pick_key(prior.slot_two), pick_key(prior.slot_three),
                            pick_key(prior.slot_four), pick_key(prior.slot_five));
        r = $urandom_range(99);
        if (r < 5) begin
            // gamepad id that still passes as a keyboard report
            b.modifier_byte = GamepadId;
            b.slot_zero     = 8'h00;
            b.reserved_byte = 8'($urandom_range(8'h3F));
        end else if (r < 20) begin
            case ($urandom_range(3))
                0: b = removal_notice();
                1: b.report_length = 7'($urandom_range(7));
                2: begin
                    b.modifier_byte = GamepadId;
                    if ($urandom_range(1)) begin
                        b.slot_zero = 8'($urandom_range(1, 255));
                    end else begin
                        b.slot_zero     = 8'h00;
                        b.reserved_byte = 8'($urandom_range(8'h40, 8'hFF));
                    end
                end
                default: b.report_length = 7'($urandom_range(65, 127));
            endcase
        end
        return b;
    endfunction

    // offer one beat, with an optional gap first, and wait for it to be taken
    task automatic send_beat(input t_in_beat b, output bit acted);
        if (!steady && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        acted = ledger.take_report(b);
    endtask

    // drop valid and wait until every due event is out
    task automatic drain_events();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (ledger.pending() != 0);
    endtask

    initial begin
        t_in_beat prior;
        t_in_beat beat;
        t_in_beat directed[$];
        int       acted_count;
        bit       acted;
        bit       hold_asked;
        bit       pause_done;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: removal, full press and swap, ignored shapes, repeats, unmapped keys
        directed.push_back(removal_notice());
        directed.push_back(keyboard_report(7'd8, 8'h00, 8'h00,
                           8'h1A, 8'h04, 8'h16, 8'h07, 8'h1D, 8'h52));
        directed.push_back(keyboard_report(7'd64, 8'h00, 8'h00,
                           8'h51, 8'h50, 8'h4F, 8'h2C, 8'h2B, 8'h28));
        directed.push_back(keyboard_report(7'd7, 8'h00, 8'h00,
                           8'h29, 8'hE0, 8'h00, 8'h00, 8'h00, 8'h00));
        directed.push_back(keyboard_report(7'd0, 8'hFF, 8'hFF,
                           8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        directed.push_back(keyboard_report(7'd8, GamepadId, 8'h00,
                           8'h29, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        directed.push_back(keyboard_report(7'd8, GamepadId, GamepadAxisLimit,
                           8'h00, 8'h29, 8'h00, 8'h00, 8'h00, 8'h00));
        directed.push_back(keyboard_report(7'd8, GamepadId, 8'h3F,
                           8'h00, 8'h29, 8'hE0, 8'h00, 8'h00, 8'h00));
        directed.push_back(keyboard_report(7'd8, 8'h02, 8'h00,
                           8'h29, 8'h29, 8'hE0, 8'hE0, 8'h00, 8'h1A));
        directed.push_back(keyboard_report(7'd8, 8'h00, 8'h00,
                           8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04));
        directed.push_back(keyboard_report(7'd8, 8'h00, 8'h00,
                           8'hFF, 8'h80, 8'h01, 8'h00, 8'h00, 8'h00));
        directed.push_back(keyboard_report(7'd8, 8'h00, 8'h00,
                           8'h02, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00));
        directed.push_back(keyboard_report(7'd127, 8'hFF, 8'hFF,
                           8'h1A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        directed.push_back(removal_notice());
        directed.push_back(keyboard_report(7'd8, 8'h00, 8'h00,
                           8'h1A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        directed.push_back(keyboard_report(7'd8, 8'h00, 8'h00,
                           8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        directed.push_back(keyboard_report(7'd8, 8'h00, 8'h00,
                           8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        foreach (directed[i]) send_beat(directed[i], acted);

        // random reports evolving from the previous one
        prior       = directed[directed.size() - 1];
        acted_count = 0;
        hold_asked  = 1'b0;
        pause_done  = 1'b0;
        while (acted_count < RandomReports) begin
            if (acted_count >= 120 && !hold_asked) begin
                hold_asked = 1'b1;
                hold_req   = 1'b1;
            end
            if (acted_count >= 200 && !pause_done) begin
                pause_done = 1'b1;
                drain_events();
            end
            steady = (acted_count >= 240 && acted_count < 290);
            beat = random_report(prior);
            send_beat(beat, acted);
            if (acted) begin
                acted_count++;
                prior = beat;
            end
        end
        steady = 1'b0;

        drain_events();
        repeat (MostEvents + 8) @(posedge i_clk);
        ledger.close_out();
        if (ledger.fault_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
